[design/cmrtc_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cmrtc_pkg
// Shared constants for the clock cartridge mapper: item kinds, bus addresses,
// indirect register codes, clock read codes and battery RAM geometry.
// ---------------------------------------------------------------------------
package cmrtc_pkg;

  // item kinds carried on tuser
  localparam logic [1:0] MODE_READ  = 2'd0;
  localparam logic [1:0] MODE_WRITE = 2'd1;
  localparam logic [1:0] MODE_TICK  = 2'd2;

  // bus addresses
  localparam logic [15:0] ADDR_DATA  = 16'hA000;
  localparam logic [15:0] ADDR_SEL   = 16'hA001;
  localparam logic [15:0] ADDR_UPPER = 16'h8000;

  // indirect register codes
  localparam logic [7:0] REG_BANK_LO = 8'h00;
  localparam logic [7:0] REG_BANK_HI = 8'h01;
  localparam logic [7:0] REG_CTRL    = 8'h04;
  localparam logic [7:0] REG_CLKSET  = 8'h05;
  localparam logic [7:0] REG_ADDR_HI = 8'h06;
  localparam logic [7:0] REG_ADDR_LO = 8'h07;
  localparam logic [7:0] REG_ID      = 8'h0A;
  localparam logic [7:0] REG_RD_LO   = 8'h0C;
  localparam logic [7:0] REG_RD_HI   = 8'h0D;

  // control byte codes for clock reads
  localparam logic [7:0] CTL_ELAPSED = 8'd0;
  localparam logic [7:0] CTL_TIME    = 8'd1;
  localparam logic [7:0] CTL_DAY_LO  = 8'd7;
  localparam logic [7:0] CTL_DAY_HI  = 8'd8;
  localparam logic [7:0] CTL_MONTH   = 8'd9;

  // address pair codes selecting minutes or hours
  localparam logic [7:0] SEL_TIME_HI = 8'd4;
  localparam logic [7:0] SEL_MIN_LO  = 8'd6;
  localparam logic [7:0] SEL_HOUR_LO = 8'd7;

  // battery RAM, power of two from 32 to 256
  localparam int RAM_DEPTH = 256;
  localparam int RAM_AW    = $clog2(RAM_DEPTH);

endpackage

[design/cartridge_mapper_with_rtc.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cartridge_mapper_with_rtc
// Indirect-register cartridge mapper with seconds clock and battery RAM.
//
//   channel  dir  tdata (low bit up)        tuser
//   in_      in   address[15:0] wdata[23:16] mode[1:0]
//   out_     out  rdata[7:0] bank[12:8]      answered
//
// One item is taken every cycle unless out_ stalls; a result passes the RAM stage,
// which holds the battery RAM's registered read port, then the output register.
// Register state updates at the accepting edge, so beats may follow back to back.
// Reset clears state, valid flags and RAM valid bits at once; no clearing pass.
// A stall on out_ holds the RAM stage; in_tready drops in the same cycle once
// that stage also holds a beat.
// ---------------------------------------------------------------------------
module cartridge_mapper_with_rtc (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // address[15:0], wdata[23:16]
  input  logic [1:0]  in_tuser,   // mode[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // rdata[7:0], bank[12:8], zeros
  output logic        out_tuser   // answered
);

  import cmrtc_pkg::*;

  // BCD-style formatting of the low count byte
  function automatic logic [7:0] bcd_fmt(input logic [7:0] v, input logic is_min);
    logic [7:0] r;
    r = v;
    if (r > 8'h0F) r = r + 8'd6;
    if (r > 8'h1F) r = r + 8'd6;
    if (r > 8'h2F) r = r + 8'd6;
    if (r > 8'h3F) r = r + 8'd6;
    if (is_min && r > 8'h4F) r = r + 8'd6;
    if (is_min && r == 8'h5A) r = 8'd0;
    return r;
  endfunction

  // input fields
  logic [1:0]  in_mode;
  logic [15:0] in_addr;
  logic [7:0]  in_wdata;
  logic        in_acc;

  // architectural state
  logic [7:0]  reg_select_r, reg_select_nxt;
  logic [7:0]  ctrl_byte_r, ctrl_byte_nxt;
  logic [7:0]  addr_high_r, addr_high_nxt;
  logic [7:0]  addr_low_r, addr_low_nxt;
  logic [3:0]  seq_count_r, seq_count_nxt;
  logic [1:0]  set_flags_r, set_flags_nxt;
  logic [7:0]  last_sec_r, last_sec_nxt;
  logic [5:0]  seconds_r, seconds_nxt;
  logic [11:0] minutes_r, minutes_nxt;
  logic [11:0] hours_r, hours_nxt;
  logic [11:0] days_r, days_nxt;
  logic [11:0] month_r, month_nxt;
  logic [3:0]  bank_low_r, bank_low_nxt;
  logic        bank_high_r, bank_high_nxt;

  // ram valid bits
  logic [RAM_DEPTH-1:0] ram_vld_r;

  // tick and clock-set temporaries
  logic [5:0]  t_sec;
  logic [11:0] t_min, t_hr, t_day, t_mon;
  logic [11:0] d_x10;
  logic [3:0]  t_seq;
  logic [1:0]  t_flg;
  logic [7:0]  bcd_m, bcd_h;
  logic        sel_min, sel_hr;

  // ram access
  logic [7:0]        wr_sum, rd_cat;
  logic [RAM_AW-1:0] ram_waddr, ram_raddr;
  logic [7:0]        ram_wdata, ram_rdata;
  logic              ram_we, ram_re;

  // result of the accepting cycle
  logic [7:0] res_rdata;
  logic       res_ans, res_ram;

  // ram stage and output register
  logic       s1_valid_r, s1_adv;
  logic [7:0] s1_rdata_r;
  logic       s1_ans_r, s1_ram_r, s1_vld_r;
  logic [4:0] s1_bank_r;
  logic       out_valid_r;
  logic [7:0] out_rdata_r;
  logic       out_ans_r;
  logic [4:0] out_bank_r;

  assign in_addr  = in_tdata[15:0];
  assign in_wdata = in_tdata[23:16];
  assign in_mode  = in_tuser;
  assign in_acc   = in_tvalid && in_tready;

  // pipeline flow
  assign s1_adv    = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || s1_adv;

  // ram indices and formatted time
  assign wr_sum    = {addr_high_r[3:0], 4'b0} + addr_low_r;
  assign rd_cat    = {addr_high_r[3:0], 4'b0} | addr_low_r;
  assign ram_waddr = wr_sum[RAM_AW-1:0];
  assign ram_raddr = rd_cat[RAM_AW-1:0];
  assign ram_wdata = ctrl_byte_r | {in_wdata[3:0], 4'b0};
  assign bcd_m     = bcd_fmt(minutes_r[7:0], 1'b1);
  assign bcd_h     = bcd_fmt(hours_r[7:0], 1'b0);
  assign sel_min   = (addr_high_r == SEL_TIME_HI) && (addr_low_r == SEL_MIN_LO);
  assign sel_hr    = (addr_high_r == SEL_TIME_HI) && (addr_low_r == SEL_HOUR_LO);
  assign d_x10     = {4'b0, in_wdata} * 12'd10;

  // seconds tick with rollover chain
  always_comb begin
    t_sec = seconds_r + 6'd1;
    t_min = minutes_r;
    t_hr  = hours_r;
    t_day = days_r;
    t_mon = month_r;
    if (t_sec > 6'd59) begin
      t_sec = t_sec - 6'd60;
      t_min = t_min + 12'd1;
    end
    if (t_min > 12'd59) begin
      t_min = t_min - 12'd60;
      t_hr  = t_hr + 12'd1;
    end
    if (t_hr > 12'd24) begin
      t_hr  = t_hr - 12'd24;
      t_day = t_day + 12'd1;
    end
    if (t_day > 12'd31) begin
      t_day = t_day - 12'd31;
      t_mon = t_mon + 12'd1;
      if (t_mon > 12'd12) t_mon = t_mon - 12'd12;
    end
  end

  // item decode and state update
  always_comb begin
    reg_select_nxt = reg_select_r;
    ctrl_byte_nxt  = ctrl_byte_r;
    addr_high_nxt  = addr_high_r;
    addr_low_nxt   = addr_low_r;
    seq_count_nxt  = seq_count_r;
    set_flags_nxt  = set_flags_r;
    last_sec_nxt   = last_sec_r;
    seconds_nxt    = seconds_r;
    minutes_nxt    = minutes_r;
    hours_nxt      = hours_r;
    days_nxt       = days_r;
    month_nxt      = month_r;
    bank_low_nxt   = bank_low_r;
    bank_high_nxt  = bank_high_r;
    res_rdata      = 8'd0;
    res_ans        = 1'b0;
    res_ram        = 1'b0;
    ram_we         = 1'b0;
    ram_re         = 1'b0;
    t_seq          = seq_count_r + 4'd1;
    t_flg          = set_flags_r;
    if (t_seq == 4'd1 && in_wdata == 8'd0) t_flg[1] = 1'b1;
    if (t_seq == 4'd2 && in_wdata == 8'd1) t_flg[0] = 1'b1;
    if (in_acc) begin
      case (in_mode)
        MODE_TICK: begin
          seconds_nxt = t_sec;
          minutes_nxt = t_min;
          hours_nxt   = t_hr;
          days_nxt    = t_day;
          month_nxt   = t_mon;
          res_ans     = 1'b1;
        end
        MODE_READ: begin
          if (in_addr == ADDR_DATA) begin
            if (reg_select_r == REG_ID) begin
              res_rdata = 8'd1;
              res_ans   = 1'b1;
            end else if (reg_select_r == REG_RD_HI) begin
              res_ans = 1'b1;
              if (ctrl_byte_r == CTL_TIME) begin
                if (sel_min)     res_rdata = {4'b0, bcd_m[7:4]};
                else if (sel_hr) res_rdata = {4'b0, bcd_h[7:4]};
              end else begin
                res_ram = 1'b1;
                ram_re  = 1'b1;
              end
            end else if (reg_select_r == REG_RD_LO) begin
              res_ans = 1'b1;
              case (ctrl_byte_r)
                CTL_ELAPSED: begin
                  if (seconds_r != 6'd0) res_rdata = {2'b0, seconds_r} - last_sec_r - 8'd1;
                  last_sec_nxt = {2'b0, seconds_r};
                end
                CTL_TIME: begin
                  if (sel_min)     res_rdata = {4'b0, bcd_m[3:0]};
                  else if (sel_hr) res_rdata = {4'b0, bcd_h[3:0]};
                end
                CTL_DAY_LO: res_rdata = {4'b0, days_r[3:0]};
                CTL_DAY_HI: res_rdata = {4'b0, days_r[7:4]};
                CTL_MONTH:  res_rdata = month_r[7:0];
                default:    res_rdata = 8'd0;
              endcase
            end
          end
        end
        MODE_WRITE: begin
          if (in_addr < ADDR_UPPER) begin
            res_ans = 1'b1;
          end else if (in_addr == ADDR_SEL) begin
            reg_select_nxt = in_wdata;
            res_ans        = 1'b1;
          end else if (in_addr == ADDR_DATA) begin
            res_ans = 1'b1;
            case (reg_select_r)
              REG_BANK_LO: bank_low_nxt  = in_wdata[3:0];
              REG_BANK_HI: bank_high_nxt = in_wdata[0];
              REG_CTRL:    ctrl_byte_nxt = in_wdata;
              REG_ADDR_HI: addr_high_nxt = in_wdata;
              REG_ADDR_LO: addr_low_nxt  = in_wdata;
              REG_CLKSET: begin
                ram_we        = 1'b1;
                seq_count_nxt = t_seq;
                set_flags_nxt = t_flg;
                if (t_flg == 2'b11) begin
                  case (t_seq)
                    4'd6:  month_nxt   = {4'b0, in_wdata};
                    4'd7:  month_nxt   = month_r + d_x10;
                    4'd8:  days_nxt    = {4'b0, in_wdata};
                    4'd9:  days_nxt    = days_r + d_x10;
                    4'd10: minutes_nxt = d_x10;
                    4'd11: hours_nxt   = d_x10;
                    4'd13, 4'd14, 4'd15: begin
                      seq_count_nxt = 4'd0;
                      set_flags_nxt = 2'b00;
                    end
                    default: seq_count_nxt = t_seq;
                  endcase
                end else if (t_seq >= 4'd2) begin
                  seq_count_nxt = 4'd0;
                  set_flags_nxt = 2'b00;
                end
              end
              default: res_ans = 1'b0;
            endcase
          end
        end
        default: res_ans = 1'b0;
      endcase
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reg_select_r <= 8'd0;
      ctrl_byte_r  <= 8'd0;
      addr_high_r  <= 8'd0;
      addr_low_r   <= 8'd0;
      seq_count_r  <= 4'd0;
      set_flags_r  <= 2'd0;
      last_sec_r   <= 8'd0;
      seconds_r    <= 6'd0;
      minutes_r    <= 12'd0;
      hours_r      <= 12'd0;
      days_r       <= 12'd0;
      month_r      <= 12'd0;
      bank_low_r   <= 4'd0;
      bank_high_r  <= 1'b0;
    end else begin
      reg_select_r <= reg_select_nxt;
      ctrl_byte_r  <= ctrl_byte_nxt;
      addr_high_r  <= addr_high_nxt;
      addr_low_r   <= addr_low_nxt;
      seq_count_r  <= seq_count_nxt;
      set_flags_r  <= set_flags_nxt;
      last_sec_r   <= last_sec_nxt;
      seconds_r    <= seconds_nxt;
      minutes_r    <= minutes_nxt;
      hours_r      <= hours_nxt;
      days_r       <= days_nxt;
      month_r      <= month_nxt;
      bank_low_r   <= bank_low_nxt;
      bank_high_r  <= bank_high_nxt;
    end
  end

  // ram valid bits, cleared by reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ram_vld_r <= '0;
    end else if (ram_we) begin
      ram_vld_r[ram_waddr] <= 1'b1;
    end
  end

  // battery ram
  cmrtc_ram #(
    .WIDTH (8),
    .DEPTH (RAM_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // ram read stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_rdata_r <= res_rdata;
      s1_ans_r   <= res_ans;
      s1_ram_r   <= res_ram;
      s1_vld_r   <= ram_vld_r[ram_raddr];
      s1_bank_r  <= {bank_high_nxt, bank_low_nxt};
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_valid_r) begin
      out_rdata_r <= s1_ram_r ? (s1_vld_r ? ram_rdata : 8'd0) : s1_rdata_r;
      out_ans_r   <= s1_ans_r;
      out_bank_r  <= s1_bank_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b0, out_bank_r, out_rdata_r};
  assign out_tuser  = out_ans_r;

  // the seconds count never leaves its minute
  a_sec_range: assert property (@(posedge clk) disable iff (!rst_n)
    seconds_r < 6'd60)
    else $error("seconds count out of range");

  // an empty output register never blocks the input
  a_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_tready)
    else $error("input stalled with empty output register");

  // a held ram stage keeps its read data
  a_ram_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && s1_ram_r && s1_vld_r && !s1_adv |=> $stable(ram_rdata))
    else $error("ram read data changed while stage held");

endmodule

[design/cmrtc_ram.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cmrtc_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ---------------------------------------------------------------------------
module cmrtc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
